// ===== rtl/wvp_pkg.sv =====
// Shared types, constants and register codes for the wheel velocity PID.
package wvp_pkg;

   localparam int WHEELS     = 4;
   localparam int GAIN_SHIFT = 16;
   localparam int WHEEL_AW   = (WHEELS > 1) ? $clog2(WHEELS) : 1;

   localparam int WHEEL_W = 2;
   localparam int RPM_W   = 16;
   localparam int ERR_W   = RPM_W + 1;
   localparam int DELTA_W = ERR_W + 1;
   localparam int INTEG_W = 24;
   localparam int GAIN_W  = 24;
   localparam int LIMIT_W = 23;
   localparam int DRIVE_W = 16;
   localparam int CSR_W   = 24;

   localparam int P_W   = GAIN_W + 1 + ERR_W;
   localparam int I_W   = GAIN_W + 1 + INTEG_W;
   localparam int D_W   = GAIN_W + 1 + DELTA_W;
   localparam int SUM_W = I_W + 2;

   localparam int OUT_MAX = 32767;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65535);

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int OCC_W      = CNT_W + 1;

   localparam int STATE_W = ERR_W + INTEG_W;

   typedef enum logic [1:0] {
      CSR_PROP_GAIN,
      CSR_INTEG_GAIN_DT,
      CSR_DERIV_GAIN_PER_DT,
      CSR_INTEGRAL_LIMIT
   } csr_index_type;

   typedef enum logic {
      KIND_UPDATE,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } gains_type;

   typedef struct packed {
      kind_type                  kind;
      logic [WHEEL_W-1:0]        wheel;
      logic signed [RPM_W-1:0]   target;
      logic signed [RPM_W-1:0]   measured;
   } req_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   last_error;
      logic signed [INTEG_W-1:0] integral;
   } wheel_state_type;

   typedef struct packed {
      logic                      valid;
      logic [WHEEL_W-1:0]        wheel;
      logic signed [ERR_W-1:0]   e;
      logic signed [INTEG_W-1:0] integ;
      logic signed [DELTA_W-1:0] delta;
   } err_stage_type;

   typedef struct packed {
      logic [WHEEL_W-1:0]        wheel;
      logic [DRIVE_W-1:0]        drive;
      logic                      saturated;
   } result_type;

endpackage

// ===== rtl/wvp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module wvp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wvp_update.sv =====
// Per-wheel state read-modify-write: error, clamped integral and error delta.
module wvp_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  wvp_pkg::req_type              req,
   input  logic [wvp_pkg::LIMIT_W-1:0]   limit,
   output logic                          s1_busy,
   output wvp_pkg::err_stage_type        stage
);

   wvp_pkg::req_type          s1_ff;
   logic                      s1_valid_ff;
   logic                      valid_ff [wvp_pkg::WHEELS];
   logic                      fwd_valid_ff;
   logic [wvp_pkg::WHEEL_AW-1:0] fwd_addr_ff;
   wvp_pkg::wheel_state_type  fwd_data_ff;
   wvp_pkg::err_stage_type    s2_ff;
   wvp_pkg::err_stage_type    s2_in;

   logic [wvp_pkg::WHEEL_AW-1:0] rd_addr;
   logic [wvp_pkg::WHEEL_AW-1:0] addr1;
   logic [wvp_pkg::STATE_W-1:0]  ram_rd;
   wvp_pkg::wheel_state_type  old_state;
   wvp_pkg::wheel_state_type  new_state;
   logic                      in_range;
   logic                      wr_en;
   logic signed [wvp_pkg::ERR_W-1:0]   e;
   logic signed [wvp_pkg::INTEG_W:0]   integ_sum;
   logic signed [wvp_pkg::INTEG_W:0]   lim_pos;
   logic signed [wvp_pkg::INTEG_W:0]   lim_neg;
   logic signed [wvp_pkg::INTEG_W-1:0] integ;
   logic signed [wvp_pkg::DELTA_W-1:0] delta;

   assign rd_addr = wvp_pkg::WHEEL_AW'(req.wheel);
   assign addr1   = wvp_pkg::WHEEL_AW'(s1_ff.wheel);

   wvp_ram #(
      .WIDTH(wvp_pkg::STATE_W),
      .DEPTH(wvp_pkg::WHEELS)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr1),
      .wr_data(new_state),
      .rd_en  (req_fire),
      .rd_addr(rd_addr),
      .rd_data(ram_rd)
   );

   always_comb begin
      in_range = (int'(s1_ff.wheel) < wvp_pkg::WHEELS);
      if (fwd_valid_ff && (fwd_addr_ff == addr1)) begin
         old_state = fwd_data_ff;
      end else if (in_range && valid_ff[addr1]) begin
         old_state = ram_rd;
      end else begin
         old_state = '0;
      end

      e = wvp_pkg::ERR_W'(s1_ff.target) - wvp_pkg::ERR_W'(s1_ff.measured);
      integ_sum = (wvp_pkg::INTEG_W + 1)'(old_state.integral) + (wvp_pkg::INTEG_W + 1)'(e);
      lim_pos = signed'((wvp_pkg::INTEG_W + 1)'(limit));
      lim_neg = -lim_pos;
      if (integ_sum > lim_pos) begin
         integ = wvp_pkg::INTEG_W'(lim_pos);
      end else if (integ_sum < lim_neg) begin
         integ = wvp_pkg::INTEG_W'(lim_neg);
      end else begin
         integ = wvp_pkg::INTEG_W'(integ_sum);
      end
      delta = wvp_pkg::DELTA_W'(e) - wvp_pkg::DELTA_W'(old_state.last_error);

      wr_en = s1_valid_ff && in_range;
      if (s1_ff.kind == wvp_pkg::KIND_CLEAR) begin
         new_state = '0;
      end else begin
         new_state.last_error = e;
         new_state.integral   = integ;
      end

      s2_in.valid = s1_valid_ff && in_range && (s1_ff.kind == wvp_pkg::KIND_UPDATE);
      s2_in.wheel = s1_ff.wheel;
      s2_in.e     = e;
      s2_in.integ = integ;
      s2_in.delta = delta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         s2_ff.valid  <= 1'b0;
         for (int i = 0; i < wvp_pkg::WHEELS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         s1_valid_ff  <= req_fire;
         fwd_valid_ff <= wr_en;
         s2_ff.valid  <= s2_in.valid;
         if (wr_en) begin
            valid_ff[addr1] <= 1'b1;
         end
      end
      if (req_fire) begin
         s1_ff <= req;
      end
      fwd_addr_ff <= addr1;
      fwd_data_ff <= new_state;
      s2_ff.wheel <= s2_in.wheel;
      s2_ff.e     <= s2_in.e;
      s2_ff.integ <= s2_in.integ;
      s2_ff.delta <= s2_in.delta;
   end

   assign s1_busy = s1_valid_ff;
   assign stage   = s2_ff;

   a_fwd_follows_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (fwd_valid_ff && (fwd_addr_ff == $past(addr1))))
      else $error("forwarding register missed a state write");

   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.kind == wvp_pkg::KIND_CLEAR)) |=> !s2_ff.valid)
      else $error("clear word produced a result");

   a_written_marked: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(addr1)])
      else $error("written wheel entry not marked valid");

endmodule

// ===== rtl/wvp_calc.sv =====
// Gain multiplies, scaling, summation and output saturation.
module wvp_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  wvp_pkg::err_stage_type stage,
   input  wvp_pkg::gains_type     gains,
   output logic                   result_valid,
   output wvp_pkg::result_type    result
);

   logic                             prod_valid_ff;
   logic [wvp_pkg::WHEEL_W-1:0]      prod_wheel_ff;
   logic signed [wvp_pkg::P_W-1:0]   p_ff;
   logic signed [wvp_pkg::I_W-1:0]   i_ff;
   logic signed [wvp_pkg::D_W-1:0]   d_ff;
   logic signed [wvp_pkg::P_W-1:0]   p_in;
   logic signed [wvp_pkg::I_W-1:0]   i_in;
   logic signed [wvp_pkg::D_W-1:0]   d_in;
   logic signed [wvp_pkg::SUM_W-1:0] p_term;
   logic signed [wvp_pkg::SUM_W-1:0] i_term;
   logic signed [wvp_pkg::SUM_W-1:0] d_term;
   logic signed [wvp_pkg::SUM_W-1:0] sum;
   logic signed [wvp_pkg::SUM_W-1:0] out_max;
   logic signed [wvp_pkg::SUM_W-1:0] clamped;

   always_comb begin
      p_in = wvp_pkg::P_W'(signed'({1'b0, gains.prop}))  * wvp_pkg::P_W'(stage.e);
      i_in = wvp_pkg::I_W'(signed'({1'b0, gains.integ})) * wvp_pkg::I_W'(stage.integ);
      d_in = wvp_pkg::D_W'(signed'({1'b0, gains.deriv})) * wvp_pkg::D_W'(stage.delta);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= stage.valid;
      end
      prod_wheel_ff <= stage.wheel;
      p_ff <= p_in;
      i_ff <= i_in;
      d_ff <= d_in;
   end

   always_comb begin
      p_term  = wvp_pkg::SUM_W'(p_ff) >>> wvp_pkg::GAIN_SHIFT;
      i_term  = wvp_pkg::SUM_W'(i_ff) >>> wvp_pkg::GAIN_SHIFT;
      d_term  = wvp_pkg::SUM_W'(d_ff) >>> wvp_pkg::GAIN_SHIFT;
      sum     = p_term + i_term + d_term;
      out_max = wvp_pkg::SUM_W'(wvp_pkg::OUT_MAX);
      result.saturated = 1'b1;
      if (sum > out_max) begin
         clamped = out_max;
      end else if (sum < -out_max) begin
         clamped = -out_max;
      end else begin
         clamped = sum;
         result.saturated = 1'b0;
      end
      result.drive = wvp_pkg::DRIVE_W'(-clamped);
      result.wheel = prod_wheel_ff;
   end

   assign result_valid = prod_valid_ff;

   a_drive_in_range: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff |-> (result.drive != wvp_pkg::DRIVE_W'(16'h8000)))
      else $error("drive reached negative full scale");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (prod_valid_ff && result.saturated) |->
         ((clamped == out_max) || (clamped == -out_max)))
      else $error("saturation flag without a clamped value");

   a_valid_follows: assert property (@(posedge clock) disable iff (reset)
      stage.valid |=> prod_valid_ff)
      else $error("product stage dropped a word");

endmodule

// ===== rtl/wvp_fifo.sv =====
// Result queue that decouples the pipeline from the output handshake.
module wvp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wvp_pkg::result_type       push_data,
   input  logic                      pop,
   output logic                      not_empty,
   output wvp_pkg::result_type       head,
   output logic [wvp_pkg::CNT_W-1:0] count
);

   wvp_pkg::result_type             entries_ff [wvp_pkg::FIFO_DEPTH];
   logic [wvp_pkg::FIFO_AW-1:0]     wr_ptr_ff;
   logic [wvp_pkg::FIFO_AW-1:0]     rd_ptr_ff;
   logic [wvp_pkg::CNT_W-1:0]       count_ff;
   logic [wvp_pkg::CNT_W-1:0]       count_in;
   logic                            do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + wvp_pkg::CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - wvp_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + wvp_pkg::FIFO_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + wvp_pkg::FIFO_AW'(1);
         end
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wvp_pkg::CNT_W'(wvp_pkg::FIFO_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == wvp_pkg::CNT_W'(wvp_pkg::FIFO_DEPTH)) |-> !(push && !do_pop))
      else $error("push into a full result queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with an empty count");

endmodule

// ===== rtl/wheel_velocity_pid.sv =====
// Top level of the per-wheel velocity PID with integral clamp.
// A result passes the request, error and product registers and the result queue to rsp.
// Throughput: one word per cycle while rsp_tready holds; the eight-entry result queue and
// the in-flight count set when req_tready drops under back-pressure.
// Reset: gains clear to zero and the integral limit becomes 65535; every wheel's state
// reads as zero through per-wheel valid bits, so no clearing pass runs.
module wheel_velocity_pid (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [39:0]                req_tdata,   // wheel, target_rpm, measured_rpm
   input  logic                       req_tuser,   // kind
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,   // wheel_out, drive
   output logic                       rsp_tuser,   // saturated
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [wvp_pkg::CSR_W-1:0]  csr_data
);

   wvp_pkg::gains_type              gains_ff;
   logic [wvp_pkg::LIMIT_W-1:0]     limit_ff;
   wvp_pkg::req_type                req;
   logic                            req_fire;
   logic                            s1_busy;
   wvp_pkg::err_stage_type          stage;
   logic                            result_valid;
   wvp_pkg::result_type             result;
   wvp_pkg::result_type             head;
   logic                            not_empty;
   logic [wvp_pkg::CNT_W-1:0]       count;
   logic [wvp_pkg::OCC_W-1:0]       occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
         limit_ff <= wvp_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (wvp_pkg::csr_index_type'(csr_index))
            wvp_pkg::CSR_PROP_GAIN:         gains_ff.prop  <= csr_data;
            wvp_pkg::CSR_INTEG_GAIN_DT:     gains_ff.integ <= csr_data;
            wvp_pkg::CSR_DERIV_GAIN_PER_DT: gains_ff.deriv <= csr_data;
            wvp_pkg::CSR_INTEGRAL_LIMIT:    limit_ff <= wvp_pkg::LIMIT_W'(csr_data);
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      req.kind     = wvp_pkg::kind_type'(req_tuser);
      req.wheel    = req_tdata[1:0];
      req.target   = req_tdata[17:2];
      req.measured = req_tdata[33:18];
      occupancy = wvp_pkg::OCC_W'(count) + wvp_pkg::OCC_W'(s1_busy)
                + wvp_pkg::OCC_W'(stage.valid) + wvp_pkg::OCC_W'(result_valid);
   end

   assign req_tready = (occupancy < wvp_pkg::OCC_W'(wvp_pkg::FIFO_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   wvp_update u_update (
      .clock   (clock),
      .reset   (reset),
      .req_fire(req_fire),
      .req     (req),
      .limit   (limit_ff),
      .s1_busy (s1_busy),
      .stage   (stage)
   );

   wvp_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .gains       (gains_ff),
      .result_valid(result_valid),
      .result      (result)
   );

   wvp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (result_valid),
      .push_data(result),
      .pop      (rsp_tready),
      .not_empty(not_empty),
      .head     (head),
      .count    (count)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = {6'b0, head.drive, head.wheel};
   assign rsp_tuser  = head.saturated;

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (occupancy >= wvp_pkg::OCC_W'(wvp_pkg::FIFO_DEPTH)) |-> !req_fire)
      else $error("request taken with no room for its result");

   a_limit_reset: assert property (@(posedge clock)
      $past(reset) |-> (limit_ff == wvp_pkg::LIMIT_RESET))
      else $error("integral limit not at its reset value");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= wvp_pkg::OCC_W'(wvp_pkg::FIFO_DEPTH))
      else $error("more words in flight than the queue can hold");

endmodule

// ===== tb/wheel_velocity_pid_check.sv =====
// Checker for the wheel velocity PID: predicts each drive word and compares it with the block.
module wheel_velocity_pid_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [39:0]                req_tdata,
   input  logic                       req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [23:0]                rsp_tdata,
   input  logic                       rsp_tuser,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [wvp_pkg::CSR_W-1:0]  csr_data,
   output int                         drives_outstanding,
   output int                         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   wvp_pkg::gains_type                         gains;
   logic [wvp_pkg::LIMIT_W-1:0]                integ_limit;
   logic signed [wvp_pkg::ERR_W-1:0]           err_hist [wvp_pkg::WHEELS];
   logic signed [wvp_pkg::INTEG_W-1:0]         error_sum [wvp_pkg::WHEELS];
   wvp_pkg::result_type                        drive_queue [$];

   initial begin
      drives_outstanding = 0;
      mismatch_count = 0;
   end

   function automatic bit predict_drive(input wvp_pkg::req_type rq,
                                        output wvp_pkg::result_type rs);
      longint e, acc, lim, p, ip, dp, sum;
      bit     sat;
      rs = '0;
      if (rq.wheel >= wvp_pkg::WHEELS)
         return 0;
      if (rq.kind == wvp_pkg::KIND_CLEAR) begin
         err_hist[rq.wheel] = '0;
         error_sum[rq.wheel] = '0;
         return 0;
      end
      e = longint'(rq.target) - longint'(rq.measured);
      lim = longint'(integ_limit);
      acc = longint'(error_sum[rq.wheel]) + e;
      if (acc > lim)
         acc = lim;
      else if (acc < -lim)
         acc = -lim;
      p = (longint'(gains.prop) * e) >>> wvp_pkg::GAIN_SHIFT;
      ip = (longint'(gains.integ) * acc) >>> wvp_pkg::GAIN_SHIFT;
      dp = (longint'(gains.deriv) * (e - longint'(err_hist[rq.wheel])))
           >>> wvp_pkg::GAIN_SHIFT;
      sum = p + ip + dp;
      sat = 0;
      if (sum > wvp_pkg::OUT_MAX) begin
         sum = wvp_pkg::OUT_MAX;
         sat = 1;
      end else if (sum < -wvp_pkg::OUT_MAX) begin
         sum = -wvp_pkg::OUT_MAX;
         sat = 1;
      end
      err_hist[rq.wheel] = wvp_pkg::ERR_W'(e);
      error_sum[rq.wheel] = wvp_pkg::INTEG_W'(acc);
      rs.wheel = rq.wheel;
      rs.drive = wvp_pkg::DRIVE_W'(-sum);
      rs.saturated = sat;
      return 1;
   endfunction

   task automatic report(input string what, input wvp_pkg::result_type want,
                         input wvp_pkg::result_type got);
      if (mismatch_count < 10)
         $display("%t %s: expected wheel %0d drive %0d sat %0d, got wheel %0d drive %0d sat %0d",
                  $realtime, what, want.wheel, $signed(want.drive), want.saturated,
                  got.wheel, $signed(got.drive), got.saturated);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      wvp_pkg::result_type got, want, calc;
      wvp_pkg::req_type    rq;
      if (reset) begin
         gains = '0;
         integ_limit = wvp_pkg::LIMIT_RESET;
         for (int i = 0; i < wvp_pkg::WHEELS; i++) begin
            err_hist[i] = '0;
            error_sum[i] = '0;
         end
         drive_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.wheel = rsp_tdata[1:0];
            got.drive = rsp_tdata[17:2];
            got.saturated = rsp_tuser;
            if (drive_queue.size() == 0) begin
               report("unexpected word", '0, got);
            end else begin
               want = drive_queue.pop_front();
               if (got.wheel != want.wheel || got.drive != want.drive
                   || got.saturated != want.saturated)
                  report("mismatch", want, got);
            end
         end
         if (csr_valid && csr_ready) begin
            case (wvp_pkg::csr_index_type'(csr_index))
               wvp_pkg::CSR_PROP_GAIN:         gains.prop = csr_data;
               wvp_pkg::CSR_INTEG_GAIN_DT:     gains.integ = csr_data;
               wvp_pkg::CSR_DERIV_GAIN_PER_DT: gains.deriv = csr_data;
               wvp_pkg::CSR_INTEGRAL_LIMIT:    integ_limit = csr_data[wvp_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            rq.kind = wvp_pkg::kind_type'(req_tuser);
            rq.wheel = req_tdata[1:0];
            rq.target = req_tdata[17:2];
            rq.measured = req_tdata[33:18];
            if (predict_drive(rq, calc))
               drive_queue.push_back(calc);
         end
      end
      drives_outstanding <= drive_queue.size();
   end

endmodule

// ===== tb/wheel_velocity_pid_test.sv =====
// Top of the wheel velocity PID testbench: clock, reset, stimulus and verdict.
module wheel_velocity_pid_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [39:0]                req_tdata;
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [23:0]                rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [1:0]                 csr_index;
   logic [wvp_pkg::CSR_W-1:0]  csr_data;
   int                         drives_outstanding;
   int                         mismatch_count;
   bit                         quiet;
   bit                         long_hold;

   wheel_velocity_pid dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   wheel_velocity_pid_check check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .drives_outstanding(drives_outstanding),
      .mismatch_count(mismatch_count)
   );

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      #20_000_000;
      $display("wheel_velocity_pid_test: errors");
      $finish;
   end

   // The receiver stalls in random bursts, and once for a long stretch so the block backs up.
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 0;
            repeat (120) @(negedge clock);
            long_hold = 0;
            rsp_tready = 1;
         end else if (!quiet && !reset && $urandom_range(0, 4) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_tready = 1;
         end else begin
            rsp_tready = 1;
         end
      end
   end

   task automatic write_reg(input wvp_pkg::csr_index_type idx,
                            input logic [wvp_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic send_word(input wvp_pkg::kind_type kind, input logic [1:0] wheel,
                            input logic signed [15:0] target, input logic signed [15:0] measured);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = kind;
      req_tdata = {6'b0, measured, target, wheel};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 0;
      while (drives_outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [wvp_pkg::CSR_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 24'hFFFFFF;
         2, 3, 4: return wvp_pkg::CSR_W'($urandom_range(0, 131072));
         default: return wvp_pkg::CSR_W'($urandom);
      endcase
   endfunction

   function automatic logic [wvp_pkg::CSR_W-1:0] pick_limit();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 24'h7FFFFF;
         2, 3, 4: return wvp_pkg::CSR_W'($urandom_range(0, 4096));
         default: return wvp_pkg::CSR_W'($urandom & 32'h7FFFFF);
      endcase
   endfunction

   task automatic random_word();
      wvp_pkg::kind_type  kind;
      logic [1:0]         wheel;
      logic signed [15:0] target, measured;
      logic signed [15:0] picks [4];
      picks = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
      kind = ($urandom_range(0, 15) == 0) ? wvp_pkg::KIND_CLEAR : wvp_pkg::KIND_UPDATE;
      wheel = 2'($urandom);
      target = 16'($urandom);
      measured = 16'($urandom);
      case ($urandom_range(0, 9))
         4, 5, 6, 7: measured = target - 16'($urandom_range(0, 512)) + 16'sd256;
         8: begin
            target = picks[$urandom_range(0, 3)];
            measured = picks[$urandom_range(0, 3)];
         end
         9: measured = target;
         default: ;
      endcase
      send_word(kind, wheel, target, measured);
   endtask

   task automatic random_phase(input int count, input bit hold, input bit pause);
      write_reg(wvp_pkg::CSR_PROP_GAIN, pick_gain());
      write_reg(wvp_pkg::CSR_INTEG_GAIN_DT, pick_gain());
      write_reg(wvp_pkg::CSR_DERIV_GAIN_PER_DT, pick_gain());
      write_reg(wvp_pkg::CSR_INTEGRAL_LIMIT, pick_limit());
      if (hold)
         long_hold = 1;
      for (int i = 0; i < count; i++) begin
         if (pause && i == count / 2)
            settle();
         random_word();
      end
      settle();
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      quiet = 0;
      long_hold = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Proportional term alone: the drive is the negated error, clamped at full scale.
      write_reg(wvp_pkg::CSR_PROP_GAIN, 24'd65536);
      write_reg(wvp_pkg::CSR_INTEG_GAIN_DT, 24'd0);
      write_reg(wvp_pkg::CSR_DERIV_GAIN_PER_DT, 24'd0);
      write_reg(wvp_pkg::CSR_INTEGRAL_LIMIT, 24'd100);
      for (int w = 0; w < wvp_pkg::WHEELS; w++)
         send_word(wvp_pkg::KIND_CLEAR, 2'(w), 16'sd0, 16'sd0);
      send_word(wvp_pkg::KIND_UPDATE, 2'd0, 16'sd32767, 16'sd0);
      send_word(wvp_pkg::KIND_UPDATE, 2'd1, 16'sd32767, -16'sd1);
      send_word(wvp_pkg::KIND_UPDATE, 2'd2, 16'sd0, 16'sd32767);
      send_word(wvp_pkg::KIND_UPDATE, 2'd3, -16'sd1, 16'sd32767);
      send_word(wvp_pkg::KIND_UPDATE, 2'd0, 16'sd32767, 16'sh8000);
      send_word(wvp_pkg::KIND_UPDATE, 2'd1, 16'sh8000, 16'sd32767);
      send_word(wvp_pkg::KIND_UPDATE, 2'd2, 16'sd0, 16'sd0);
      send_word(wvp_pkg::KIND_UPDATE, 2'd3, -16'sd1, 16'sd0);
      settle();

      // Half proportional and full integral and derivative gains with the widest integral bound, then a zero bound.
      write_reg(wvp_pkg::CSR_PROP_GAIN, 24'd32768);
      write_reg(wvp_pkg::CSR_INTEG_GAIN_DT, 24'hFFFFFF);
      write_reg(wvp_pkg::CSR_DERIV_GAIN_PER_DT, 24'hFFFFFF);
      write_reg(wvp_pkg::CSR_INTEGRAL_LIMIT, 24'h7FFFFF);
      send_word(wvp_pkg::KIND_UPDATE, 2'd0, -16'sd1, 16'sd0);
      send_word(wvp_pkg::KIND_UPDATE, 2'd1, 16'sd1, 16'sd0);
      send_word(wvp_pkg::KIND_CLEAR, 2'd1, 16'sd0, 16'sd0);
      send_word(wvp_pkg::KIND_UPDATE, 2'd1, 16'sd100, -16'sd100);
      send_word(wvp_pkg::KIND_UPDATE, 2'd2, 16'sh8000, 16'sd32767);
      settle();
      write_reg(wvp_pkg::CSR_PROP_GAIN, 24'hFFFFFF);
      write_reg(wvp_pkg::CSR_INTEGRAL_LIMIT, 24'd0);
      send_word(wvp_pkg::KIND_UPDATE, 2'd0, 16'sd32767, 16'sd32767);
      send_word(wvp_pkg::KIND_UPDATE, 2'd3, 16'sh8000, 16'sh8000);
      send_word(wvp_pkg::KIND_UPDATE, 2'd0, 16'sd12, 16'sd5);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7)
            quiet = 1;
         random_phase(250, ph == 3, ph == 5);
      end

      if (mismatch_count == 0 && drives_outstanding == 0)
         $display("wheel_velocity_pid_test: clean");
      else
         $display("wheel_velocity_pid_test: errors");
      $finish;
   end

endmodule
